FILE: src/point_rigid_transform_assert.svh
// Assertion macros for the point rigid transform block.
// Needs clk and rst_n in scope at the point of use; define ASSERT_OFF to drop all checks.
`ifndef POINT_RIGID_TRANSFORM_ASSERT_SVH
`define POINT_RIGID_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only out of reset
`define PRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("point_rigid_transform: check failed");
// Checked on every edge, reset included
`define PRT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("point_rigid_transform: check failed");
`else
`define PRT_ASSERT(lbl, prop)
`define PRT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/prt_pkg.sv
// Shared types and constants for the point rigid transform block.
// No dependencies.
`default_nettype none
package prt_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int ROT_W          = 3 * COEF_BITS;
  localparam int TRANS_BITS     = 21;
  localparam int TRANS_W        = 3 * TRANS_BITS;
  // Destination index width; the fused cloud holds 2**INDEX_BITS points
  localparam int INDEX_BITS     = 20;
  localparam int INTENS_W       = 8;
  localparam int TS_W           = 64;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0    = 3'd0,
    CFG_ROT_ROW1    = 3'd1,
    CFG_ROT_ROW2    = 3'd2,
    CFG_TRANSLATION = 3'd3,
    CFG_XFORM_EN    = 3'd4,
    CFG_NAN_FILT_EN = 3'd5,
    CFG_TIME_OFFSET = 3'd6,
    CFG_BASE_INDEX  = 3'd7
  } cfg_idx_t;

  typedef logic [ROT_W-1:0]      rot_row_t;
  typedef logic [TRANS_W-1:0]    trans_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [TS_W-1:0]       ts_t;

endpackage
`default_nettype wire

FILE: src/prt_coord_unit.sv
// One output coordinate: dot product of a rotation row with the point, plus translation,
// rounded to whole mm and saturated. Depends on prt_pkg.
`default_nettype none
module prt_coord_unit #(
  parameter int COORD_BITS = 24
) (
  input  prt_pkg::rot_row_t              row,
  input  logic signed [prt_pkg::TRANS_BITS-1:0] trans,
  input  logic signed [COORD_BITS-1:0]   x,
  input  logic signed [COORD_BITS-1:0]   y,
  input  logic signed [COORD_BITS-1:0]   z,
  output logic signed [COORD_BITS-1:0]   res
);
  import prt_pkg::*;

  localparam int PROD_W = COEF_BITS + COORD_BITS;
  localparam int T_W    = TRANS_BITS + COEF_FRAC_BITS;
  // three products plus translation plus rounding: three guard bits
  localparam int ACC_W  = ((PROD_W > T_W) ? PROD_W : T_W) + 3;
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0]   Q_HI = {{(Q_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_LO = {{(Q_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0] c0, c1, c2;
  logic signed [PROD_W-1:0]    p0, p1, p2;
  logic signed [ACC_W-1:0]     acc;
  logic signed [Q_W-1:0]       q;

  assign c0 = row[0*COEF_BITS +: COEF_BITS];
  assign c1 = row[1*COEF_BITS +: COEF_BITS];
  assign c2 = row[2*COEF_BITS +: COEF_BITS];

  assign p0 = c0 * x;
  assign p1 = c1 * y;
  assign p2 = c2 * z;

  assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2)
             + (ACC_W'(trans) <<< COEF_FRAC_BITS) + RND;

  // arithmetic shift is floor, so ties go toward plus infinity
  assign q = Q_W'(acc >>> COEF_FRAC_BITS);

  always_comb begin
    if (q > Q_HI) begin
      res = Q_HI[COORD_BITS-1:0];
    end else if (q < Q_LO) begin
      res = Q_LO[COORD_BITS-1:0];
    end else begin
      res = q[COORD_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/point_rigid_transform.sv
// Streaming rigid-body transform of lidar points: one point word in, one result word out.
//
// Channels: in_* carries a point word (valid/stall), out_* carries the result word
// (valid/stall). A word moves at a rising edge with valid high and stall low.
// cfg_we/cfg_index/cfg_data write the eight setup registers; write them only while
// the block holds no point.
// An accepted point sits in the input register; the rotate/translate/round/saturate logic
// feeds the result register, which loads it when out_stall allows; out_valid is then high.
// Throughput is one point per cycle while out_stall is low, set by the single pass through
// the three 18 x COORD_BITS multipliers and their adder per coordinate.
// Every point gives exactly one result; dropped points show out_write_enable low,
// the next free index on out_dest_index and zero coordinates, intensity and time.
// Stall: with out_stall high and the result register full, the input register still
// takes one more word; in_stall rises only when both registers are full.
// Reset (rst_n low, synchronous): both registers empty, kept-point count zero,
// identity rotation, zero translation, transform and filter off, zero offset and base.
// The kept-point count returns to zero after each end-of-cloud word.
`default_nettype none
module point_rigid_transform #(
  parameter int COORD_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  prt_pkg::cfg_idx_t                  cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]     cfg_data,
  // point words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_x,
  input  logic signed [COORD_BITS-1:0]       in_y,
  input  logic signed [COORD_BITS-1:0]       in_z,
  input  logic [prt_pkg::INTENS_W-1:0]       in_intensity,
  input  prt_pkg::ts_t                       in_timestamp,
  input  logic                               in_invalid,
  input  logic                               in_last,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_write_enable,
  output prt_pkg::index_t                    out_dest_index,
  output logic signed [COORD_BITS-1:0]       out_x,
  output logic signed [COORD_BITS-1:0]       out_y,
  output logic signed [COORD_BITS-1:0]       out_z,
  output logic [prt_pkg::INTENS_W-1:0]       out_intensity,
  output prt_pkg::ts_t                       out_timestamp,
  output logic                               out_last
);
  import prt_pkg::*;

  `include "point_rigid_transform_assert.svh"

  localparam rot_row_t ROT0_RST = ROT_W'(1) << COEF_FRAC_BITS;
  localparam rot_row_t ROT1_RST = ROT_W'(1) << (COEF_FRAC_BITS + COEF_BITS);
  localparam rot_row_t ROT2_RST = ROT_W'(1) << (COEF_FRAC_BITS + 2 * COEF_BITS);

  // ---- setup registers ----
  rot_row_t rot0_r, rot1_r, rot2_r;
  trans_t   trans_r;
  logic     xform_en_r, filt_en_r;
  ts_t      toff_r;
  index_t   base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r     <= ROT0_RST;
      rot1_r     <= ROT1_RST;
      rot2_r     <= ROT2_RST;
      trans_r    <= '0;
      xform_en_r <= 1'b0;
      filt_en_r  <= 1'b0;
      toff_r     <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROT_ROW0:    rot0_r     <= cfg_data[ROT_W-1:0];
        CFG_ROT_ROW1:    rot1_r     <= cfg_data[ROT_W-1:0];
        CFG_ROT_ROW2:    rot2_r     <= cfg_data[ROT_W-1:0];
        CFG_TRANSLATION: trans_r    <= cfg_data[TRANS_W-1:0];
        CFG_XFORM_EN:    xform_en_r <= cfg_data[0];
        CFG_NAN_FILT_EN: filt_en_r  <= cfg_data[0];
        CFG_TIME_OFFSET: toff_r     <= cfg_data[TS_W-1:0];
        CFG_BASE_INDEX:  base_r     <= cfg_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- handshake ----
  logic s1_vld_r, s1_vld_nxt;
  logic s2_vld_r, s2_vld_nxt;
  logic adv2;   // result register can take a word this cycle
  logic load1;  // input register takes in_* this cycle
  logic move;   // a word goes from input to result register

  assign adv2     = !s2_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv2;
  assign load1    = !in_stall;
  assign move     = s1_vld_r && adv2;

  assign s1_vld_nxt = load1 ? in_valid : s1_vld_r;
  assign s2_vld_nxt = adv2 ? s1_vld_r : s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // ---- input register ----
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [INTENS_W-1:0]          s1_int_r;
  ts_t                          s1_ts_r;
  logic                         s1_inv_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
      s1_z_r    <= in_z;
      s1_int_r  <= in_intensity;
      s1_ts_r   <= in_timestamp;
      s1_inv_r  <= in_invalid;
      s1_last_r <= in_last;
    end
  end

  // ---- transform ----
  logic signed [COORD_BITS-1:0] rx, ry, rz;

  prt_coord_unit #(.COORD_BITS(COORD_BITS)) u_cx (
    .row(rot0_r), .trans(trans_r[0*TRANS_BITS +: TRANS_BITS]),
    .x(s1_x_r), .y(s1_y_r), .z(s1_z_r), .res(rx)
  );
  prt_coord_unit #(.COORD_BITS(COORD_BITS)) u_cy (
    .row(rot1_r), .trans(trans_r[1*TRANS_BITS +: TRANS_BITS]),
    .x(s1_x_r), .y(s1_y_r), .z(s1_z_r), .res(ry)
  );
  prt_coord_unit #(.COORD_BITS(COORD_BITS)) u_cz (
    .row(rot2_r), .trans(trans_r[2*TRANS_BITS +: TRANS_BITS]),
    .x(s1_x_r), .y(s1_y_r), .z(s1_z_r), .res(rz)
  );

  logic keep, apply;
  assign keep  = !(s1_inv_r && filt_en_r);
  assign apply = xform_en_r && !s1_inv_r;   // invalid points are never transformed

  // ---- kept-point count ----
  index_t kept_r, kept_nxt;

  always_comb begin
    kept_nxt = kept_r;
    if (move) begin
      if (s1_last_r) begin
        kept_nxt = '0;
      end else if (keep) begin
        kept_nxt = kept_r + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
    end else begin
      kept_r <= kept_nxt;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (move) begin
      out_write_enable <= keep;
      out_dest_index   <= base_r + kept_r;
      out_last         <= s1_last_r;
      if (!keep) begin
        out_x         <= '0;
        out_y         <= '0;
        out_z         <= '0;
        out_intensity <= '0;
        out_timestamp <= '0;
      end else begin
        out_x         <= apply ? rx : s1_x_r;
        out_y         <= apply ? ry : s1_y_r;
        out_z         <= apply ? rz : s1_z_r;
        out_intensity <= s1_int_r;
        out_timestamp <= s1_ts_r - toff_r;
      end
    end
  end

  assign out_valid = s2_vld_r;

  // ---- checks ----
  `PRT_ASSERT(a_drop_zero, out_valid && !out_write_enable |-> out_x == '0 && out_y == '0 && out_z == '0 && out_timestamp == '0)
  `PRT_ASSERT(a_last_clears, move && s1_last_r |=> kept_r == '0)
  `PRT_ASSERT(a_count_hold, !move |=> $stable(kept_r))
  `PRT_ASSERT_ALWAYS(a_stall_full, in_stall |-> s1_vld_r && s2_vld_r && out_stall)

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for point_rigid_transform: directed corner words, then random clouds.
// Results are predicted in-bench (rotate, translate, round, saturate, filter, index, time).
// Depends on prt_pkg and the point_rigid_transform RTL.
module testbench;
  import prt_pkg::*;

  localparam int CW          = 24;
  localparam int ONE         = 1 << COEF_FRAC_BITS;
  localparam int COEF_MAX    = (1 << (COEF_BITS - 1)) - 1;
  localparam int COEF_MIN    = -(1 << (COEF_BITS - 1));
  localparam int T_MAX       = (1 << (TRANS_BITS - 1)) - 1;
  localparam int T_MIN       = -(1 << (TRANS_BITS - 1));
  localparam int C_MAX       = (1 << (CW - 1)) - 1;
  localparam int C_MIN       = -(1 << (CW - 1));
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 75;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [INTENS_W-1:0]   intensity;
    ts_t                   ts;
    logic                  invalid;
    logic                  last;
  } point_t;

  typedef struct packed {
    logic                  keep;
    index_t                dest;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [INTENS_W-1:0]   intensity;
    ts_t                   ts;
    logic                  last;
  } result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_ROT_ROW0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  coord_t                in_x = '0;
  coord_t                in_y = '0;
  coord_t                in_z = '0;
  logic [INTENS_W-1:0]   in_intensity = '0;
  ts_t                   in_timestamp = '0;
  logic                  in_invalid = 1'b0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_write_enable;
  index_t                out_dest_index;
  coord_t                out_x;
  coord_t                out_y;
  coord_t                out_z;
  logic [INTENS_W-1:0]   out_intensity;
  ts_t                   out_timestamp;
  logic                  out_last;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_rigid_transform #(.COORD_BITS(CW)) u_dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the setup registers and the kept count
  // ---------------------------------------------------------------------------
  rot_row_t rot_m [3];
  trans_t   trans_m = '0;
  logic     xform_m = 1'b0;
  logic     filt_m = 1'b0;
  ts_t      offset_m = '0;
  index_t   base_m = '0;
  index_t   kept_m = '0;   // 20 bits, so it wraps at the cloud size by itself

  result_t  due_words [$];  // predicted results, oldest first

  int gap_max = 15;      // sender idle cycles drawn per word, 0..gap_max
  int stall_max = 15;    // receiver stall cycles drawn per word, 0..stall_max
  int mismatch_count = 0;
  int words_sent = 0;
  int kept_seen = 0;
  int dropped_seen = 0;
  int ends_seen = 0;
  int reg_writes = 0;

  function automatic rot_row_t pack_row(input int c0, input int c1, input int c2);
    return {COEF_BITS'(c2), COEF_BITS'(c1), COEF_BITS'(c0)};
  endfunction

  function automatic trans_t pack_trans(input int t0, input int t1, input int t2);
    return {TRANS_BITS'(t2), TRANS_BITS'(t1), TRANS_BITS'(t0)};
  endfunction

  // One output coordinate: row . (x,y,z) + t, in Q.16, rounded half up, clamped
  function automatic coord_t map_coord(input int k, input point_t p);
    longint acc;
    acc = longint'($signed(rot_m[k][0 +: COEF_BITS])) * longint'($signed(p.x))
        + longint'($signed(rot_m[k][COEF_BITS +: COEF_BITS])) * longint'($signed(p.y))
        + longint'($signed(rot_m[k][2*COEF_BITS +: COEF_BITS])) * longint'($signed(p.z))
        + (longint'($signed(trans_m[k*TRANS_BITS +: TRANS_BITS])) <<< COEF_FRAC_BITS)
        + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    acc = acc >>> COEF_FRAC_BITS;   // arithmetic shift = floor
    if (acc > C_MAX) acc = C_MAX;
    else if (acc < C_MIN) acc = C_MIN;
    return acc[CW-1:0];
  endfunction

  // Result word for one accepted point; advances the kept count
  function automatic result_t transform_point(input point_t p);
    result_t r;
    r = '0;
    r.dest = base_m + kept_m;
    r.last = p.last;
    if (!(p.invalid && filt_m)) begin
      r.keep = 1'b1;
      if (xform_m && !p.invalid) begin
        r.x = map_coord(0, p);
        r.y = map_coord(1, p);
        r.z = map_coord(2, p);
      end else begin
        r.x = p.x;
        r.y = p.y;
        r.z = p.z;
      end
      r.intensity = p.intensity;
      r.ts = p.ts - offset_m;
      kept_m = kept_m + INDEX_BITS'(1);
    end
    if (p.last) kept_m = '0;
    return r;
  endfunction

  function automatic point_t pt(input int x, input int y, input int z,
                               input logic [INTENS_W-1:0] inten, input ts_t ts,
                               input logic bad, input logic last);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.intensity = inten;
    p.ts = ts;
    p.invalid = bad;
    p.last = last;
    return p;
  endfunction

  // Realistic ranges, full-width noise and the rails, mixed
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'(C_MAX);
      1:       return coord_t'(C_MIN);
      2, 3, 4: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_BITS'(COEF_MAX);
      1:       return COEF_BITS'(COEF_MIN);
      2, 3:    return COEF_BITS'(int'($urandom_range(0, 2 * ONE)) - ONE);
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [TRANS_BITS-1:0] rand_trans();
    case ($urandom_range(0, 5))
      0:       return TRANS_BITS'(T_MAX);
      1:       return TRANS_BITS'(T_MIN);
      2, 3:    return TRANS_BITS'(int'($urandom_range(0, 20000)) - 10000);
      default: return TRANS_BITS'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    p.intensity = INTENS_W'($urandom);
    p.ts = {$urandom, $urandom};
    p.invalid = ($urandom_range(0, 7) == 0);
    p.last = ($urandom_range(0, 23) == 0);
    return p;
  endfunction

  // Extreme setups on the first two random phases, random values after that
  function automatic logic [63:0] phase_word(input int ph, input logic [63:0] rnd);
    if (ph == 0) return '1;
    if (ph == 1) return '0;
    return rnd;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Setup port: one register per write; the predictor copy follows it, masked
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROT_ROW0:    rot_m[0] = val[ROT_W-1:0];
      CFG_ROT_ROW1:    rot_m[1] = val[ROT_W-1:0];
      CFG_ROT_ROW2:    rot_m[2] = val[ROT_W-1:0];
      CFG_TRANSLATION: trans_m = val[TRANS_W-1:0];
      CFG_XFORM_EN:    xform_m = val[0];
      CFG_NAN_FILT_EN: filt_m = val[0];
      CFG_TIME_OFFSET: offset_m = val;
      CFG_BASE_INDEX:  base_m = val[INDEX_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the word until the block takes it.
  // in_valid stays high across back-to-back words so it is never dropped and
  // raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic drive_point(input point_t p);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_x         <= p.x;
    in_y         <= p.y;
    in_z         <= p.z;
    in_intensity <= p.intensity;
    in_timestamp <= p.ts;
    in_invalid   <= p.invalid;
    in_last      <= p.last;
    do @(posedge clk); while (in_stall);
    due_words = {due_words, transform_point(p)};
    words_sent++;
  endtask

  // Block idle: nothing in flight, then an extra idle wait for the result register
  task automatic settle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall per word, with stall-free stretches when stall_max = 0
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    forever begin
      hold = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  // Result checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = due_words.pop_front();
        check_field("write_enable", 64'(out_write_enable), 64'(want.keep));
        check_field("dest_index", 64'(out_dest_index), 64'(want.dest));
        check_field("x", 64'(out_x), 64'(want.x));
        check_field("y", 64'(out_y), 64'(want.y));
        check_field("z", 64'(out_z), 64'(want.z));
        check_field("intensity", 64'(out_intensity), 64'(want.intensity));
        check_field("timestamp", out_timestamp, want.ts);
        check_field("last", 64'(out_last), 64'(want.last));
        if (out_write_enable) kept_seen++;
        else dropped_seen++;
        if (out_last) ends_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setup: plain copy, invalid words kept, then the reset identity rotation
  task automatic test_reset_state();
    drive_point(pt(C_MAX, C_MIN, 0, 8'hFF, '1, 1'b0, 1'b0));
    drive_point(pt(C_MIN, C_MAX, -1, 8'h00, '0, 1'b1, 1'b0));
    drive_point(pt(1, -1, C_MAX, 8'h5A, 64'h8000_0000_0000_0000, 1'b0, 1'b1));
    settle();
    write_reg(CFG_XFORM_EN, 64'd1);
    drive_point(pt(C_MAX, C_MIN, 12345, 8'h81, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0));
    drive_point(pt(C_MIN, C_MAX, -1, 8'h7E, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1));
  endtask

  // Half-way ties round up; all-min and all-max rows drive the y and z coordinates to both rails
  task automatic test_rounding_saturation();
    settle();
    write_reg(CFG_ROT_ROW0, CFG_DATA_W'(pack_row(ONE / 2, 0, 0)));
    write_reg(CFG_ROT_ROW1, CFG_DATA_W'(pack_row(COEF_MIN, COEF_MIN, COEF_MIN)));
    write_reg(CFG_ROT_ROW2, CFG_DATA_W'(pack_row(COEF_MAX, COEF_MAX, COEF_MAX)));
    write_reg(CFG_TRANSLATION, {1'b0, pack_trans(0, T_MAX, T_MIN)});
    drive_point(pt(1, 0, 0, 8'h01, 64'd1, 1'b0, 1'b0));
    drive_point(pt(-1, 0, 0, 8'h02, 64'd2, 1'b0, 1'b0));
    drive_point(pt(3, 0, 0, 8'h03, 64'd3, 1'b0, 1'b0));
    drive_point(pt(-3, 0, 0, 8'h04, 64'd4, 1'b0, 1'b0));
    drive_point(pt(C_MAX, C_MAX, C_MAX, 8'h05, 64'd5, 1'b0, 1'b0));
    drive_point(pt(C_MIN, C_MIN, C_MIN, 8'h06, 64'd6, 1'b0, 1'b0));
    drive_point(pt(C_MAX, C_MIN, 0, 8'h07, 64'd7, 1'b0, 1'b1));
  endtask

  // Filter drops (one of them closing a cloud), time offset wrap, invalid never rotated,
  // and the filter still acting with the transform off
  task automatic test_filter_and_offset();
    settle();
    write_reg(CFG_TIME_OFFSET, '1);
    write_reg(CFG_NAN_FILT_EN, 64'd1);
    drive_point(pt(100, 200, 300, 8'h10, '1, 1'b0, 1'b0));
    drive_point(pt(C_MAX, C_MAX, C_MAX, 8'hFF, '1, 1'b1, 1'b0));
    drive_point(pt(5, 6, 7, 8'h11, 64'd0, 1'b1, 1'b1));
    drive_point(pt(-100, -200, -300, 8'h12, 64'd9, 1'b0, 1'b0));
    settle();
    write_reg(CFG_NAN_FILT_EN, 64'd0);
    write_reg(CFG_TIME_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
    drive_point(pt(C_MIN, 42, C_MAX, 8'h13, 64'd0, 1'b1, 1'b0));
    settle();
    write_reg(CFG_XFORM_EN, 64'd0);
    write_reg(CFG_NAN_FILT_EN, 64'd1);
    drive_point(pt(-7, 8, -9, 8'h14, 64'h8000_0000_0000_0000, 1'b0, 1'b0));
    drive_point(pt(1, 2, 3, 8'h15, 64'd10, 1'b1, 1'b1));
  endtask

  // Base near the top of the index space: destination wraps; upper data bits ignored
  task automatic test_index_wrap();
    point_t p;
    settle();
    write_reg(CFG_BASE_INDEX, {44'hABC_DEF0_1234, 20'hFFFFE});
    repeat (4) begin
      p = rand_point();
      p.invalid = 1'b0;
      p.last = 1'b0;
      drive_point(p);
    end
    p = rand_point();
    p.last = 1'b1;
    drive_point(p);
  endtask

  // Random clouds under a fresh setup per phase; idling varies by phase
  task automatic test_random_traffic();
    logic [63:0] base_word;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gap_max   = (ph % 3 == 0) ? 0 : 15;
      stall_max = (ph % 4 == 1) ? 0 : 15;
      base_word = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) base_word[19:0] = 20'(-int'($urandom_range(1, 40)));
      write_reg(CFG_ROT_ROW0, phase_word(ph, {10'($urandom), rand_coef(), rand_coef(),
                                             rand_coef()}));
      write_reg(CFG_ROT_ROW1, phase_word(ph, {10'($urandom), rand_coef(), rand_coef(),
                                             rand_coef()}));
      write_reg(CFG_ROT_ROW2, phase_word(ph, {10'($urandom), rand_coef(), rand_coef(),
                                             rand_coef()}));
      write_reg(CFG_TRANSLATION, phase_word(ph, {1'($urandom), rand_trans(), rand_trans(),
                                                rand_trans()}));
      write_reg(CFG_XFORM_EN, phase_word(ph, {$urandom, 31'($urandom),
                                             1'($urandom_range(0, 3) != 0)}));
      write_reg(CFG_NAN_FILT_EN, phase_word(ph, {$urandom, $urandom}));
      write_reg(CFG_TIME_OFFSET, phase_word(ph, {$urandom, $urandom}));
      write_reg(CFG_BASE_INDEX, phase_word(ph, base_word));
      repeat (PHASE_WORDS) drive_point(rand_point());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    rot_m[0] = pack_row(ONE, 0, 0);
    rot_m[1] = pack_row(0, ONE, 0);
    rot_m[2] = pack_row(0, 0, ONE);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_rounding_saturation();
    test_filter_and_offset();
    test_index_wrap();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    if (due_words.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", due_words.size()));

    $display("Covered %0d point words over %0d register writes: %0d kept, %0d dropped,",
             words_sent, reg_writes, kept_seen, dropped_seen);
    $display("%0d cloud ends; %0d mismatches", ends_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
